@@ src/bpei_pkg.sv @@
// Shared constants, types and codes of the balance effort integrator.
package bpei_pkg;

	// Word format of angles, rates, gains and commands.
	localparam int W         = 32;
	localparam int FRAC_BITS = 16;
	localparam int DT_W      = 16;
	localparam int DT_FRAC   = 16;
	localparam int LIM_W     = W - 1;

	// Digit-serial multiplier: radix-16 digits of the serial operand.
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = W / DIGIT_W;
	localparam int CNT_W   = $clog2(DIGITS);
	localparam int A_W     = W + 1;
	localparam int HI_W    = A_W + 1;
	localparam int T_W     = A_W + DIGIT_W + 1;
	localparam int P_W     = HI_W + W;

	// Width of the effort sum before its single saturation.
	localparam int EFF_W = W + 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN_P   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN_I   = 3'd5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_EFF,
		ST_EMIT
	} state_t;

	// The eight products worked through for one item, in order.
	typedef enum logic [2:0] {
		OP_TRAP_E,
		OP_MUL_I,
		OP_TRAP_U,
		OP_MUL_WI,
		OP_MUL_P,
		OP_MUL_D,
		OP_MUL_WP,
		OP_TRAP_C
	} op_t;

	// Control of the shared multiplier.
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mul_ctrl_t;

endpackage

@@ src/balance_pid_effort_integrator.sv @@
// Top level of the balance controller: tilt PID, wheel PI and integrated motor command.
//
// Usage. An input item (tilt_angle, tilt_rate, wheel_rate, sample_period) is taken
// when in_valid and in_ready are both high; each item yields exactly one result
// item, motor_command, offered on out_valid/out_ready. Gains and the integral limit
// are written through the cfg channel (cfg_index, cfg_data), which is always ready;
// indexes beyond the last register are ignored. Write them only while idle.
// Sequence: every item needs eight products on one digit-serial multiplier, each
// taking a load step, the radix-16 digit steps and a write-back step, plus a
// step to saturate the effort. The block takes the next item only once the
// previous result has been emitted into the output register, which must first
// be free. While the receiver stalls the result holds in the output register;
// the block finishes the following item and then waits with it until the held
// result is taken. Reset clears all gains, the limit, both errors, both integrals,
// the previous effort and the command accumulator.
module balance_pid_effort_integrator import bpei_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [W-1:0]   tilt_angle,
	input  logic signed [W-1:0]   tilt_rate,
	input  logic signed [W-1:0]   wheel_rate,
	input  logic [DT_W-1:0]       sample_period,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [W-1:0]   motor_command,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [W-1:0]          cfg_data
);

	localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

	// Negation that maps the most negative value to the most positive one.
	function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] x);
		if (x == W_MIN)
			return W_MAX;
		return -x;
	endfunction

	// Sign extension to the width of the effort sum.
	function automatic logic signed [EFF_W-1:0] sx(input logic signed [W-1:0] x);
		return {{(EFF_W-W){x[W-1]}}, x};
	endfunction

	// Saturation of a wider sum to one word.
	function automatic logic signed [W-1:0] sat_w(input logic signed [EFF_W-1:0] x);
		logic [EFF_W-W:0] top;
		top = x[EFF_W-1:W-1];
		if (top == '0 || top == '1)
			return x[W-1:0];
		return x[EFF_W-1] ? W_MIN : W_MAX;
	endfunction

	// Scaled gain product: floor shift by the fraction bits, then saturate.
	function automatic logic signed [W-1:0] scale_sat(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] sh;
		logic [P_W-W:0]        top;
		sh  = p >>> FRAC_BITS;
		top = sh[P_W-1:W-1];
		if (top == '0 || top == '1)
			return sh[W-1:0];
		return sh[P_W-1] ? W_MIN : W_MAX;
	endfunction

	// Symmetric clamp of the tilt integral.
	function automatic logic signed [W-1:0] clamp_lim(input logic signed [W-1:0] v,
							   input logic [LIM_W-1:0] lim);
		logic signed [W-1:0] hi;
		logic signed [W-1:0] lo;
		hi = {1'b0, lim};
		lo = -hi;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Order of the products for one item.
	function automatic op_t next_op(input op_t op);
		unique case (op)
			OP_TRAP_E: return OP_MUL_I;
			OP_MUL_I:  return OP_TRAP_U;
			OP_TRAP_U: return OP_MUL_WI;
			OP_MUL_WI: return OP_MUL_P;
			OP_MUL_P:  return OP_MUL_D;
			OP_MUL_D:  return OP_MUL_WP;
			OP_MUL_WP: return OP_TRAP_C;
			OP_TRAP_C: return OP_TRAP_E;
			default:   return OP_TRAP_E;
		endcase
	endfunction

	// Configuration registers.
	logic signed [W-1:0] gain_p_q;
	logic signed [W-1:0] gain_i_q;
	logic signed [W-1:0] gain_d_q;
	logic [LIM_W-1:0]    integral_limit_q;
	logic signed [W-1:0] wheel_gain_p_q;
	logic signed [W-1:0] wheel_gain_i_q;

	// Controller state.
	logic signed [W-1:0] tilt_err_q;
	logic signed [W-1:0] tilt_int_q;
	logic signed [W-1:0] wheel_err_q;
	logic signed [W-1:0] wheel_int_q;
	logic signed [W-1:0] last_eff_q;
	logic signed [W-1:0] cmd_q;

	// Working values of the item in flight.
	logic signed [W-1:0]     e_q;
	logic signed [W-1:0]     ed_q;
	logic signed [W-1:0]     u_q;
	logic [DT_W-1:0]         dt_q;
	logic signed [W-1:0]     tmp_q;
	logic signed [EFF_W-1:0] eff_acc_q;
	logic signed [W-1:0]     eff_q;

	// Sequencer.
	state_t           state_q;
	state_t           state_d;
	op_t              op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;
	logic             accept;
	logic             post_en;
	logic             eff_en;
	logic             emit_en;
	logic             out_free;
	mul_ctrl_t        mul_ctrl;

	// Output register.
	logic                out_valid_q;
	logic signed [W-1:0] motor_command_q;

	// Multiplier operands and results.
	logic signed [A_W-1:0] mul_a;
	logic signed [W-1:0]   mul_b;
	logic signed [P_W-1:0] product;
	logic signed [P_W-1:0] trap_sh;
	logic signed [W-1:0]   trap_val;
	logic signed [W-1:0]   scaled;
	logic signed [W-1:0]   lim_pos;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_last  = (cnt_q == CNT_W'(DIGITS - 1));
	assign accept    = in_valid && in_ready;
	assign lim_pos   = {1'b0, integral_limit_q};

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
			wheel_gain_p_q   <= '0;
			wheel_gain_i_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:         gain_p_q         <= cfg_data;
				REG_GAIN_I:         gain_i_q         <= cfg_data;
				REG_GAIN_D:         gain_d_q         <= cfg_data;
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIM_W-1:0];
				REG_WHEEL_GAIN_P:   wheel_gain_p_q   <= cfg_data;
				REG_WHEEL_GAIN_I:   wheel_gain_i_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL:  if (cnt_last) state_d = ST_POST;
			ST_POST: begin
				if (op_q == OP_MUL_WP)
					state_d = ST_EFF;
				else if (op_q == OP_TRAP_C)
					state_d = ST_EMIT;
				else
					state_d = ST_LOAD;
			end
			ST_EFF:  state_d = ST_LOAD;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready      = 1'b0;
		mul_ctrl.load = 1'b0;
		mul_ctrl.step = 1'b0;
		mul_ctrl.last = cnt_last;
		post_en       = 1'b0;
		eff_en        = 1'b0;
		emit_en       = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready      = 1'b1;
			ST_LOAD: mul_ctrl.load = 1'b1;
			ST_MUL:  mul_ctrl.step = 1'b1;
			ST_POST: post_en       = 1'b1;
			ST_EFF:  eff_en        = 1'b1;
			ST_EMIT: emit_en       = out_free;
			default: ;
		endcase
	end

	// State, product index and digit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_TRAP_E;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				op_q <= OP_TRAP_E;
			else if (post_en)
				op_q <= next_op(op_q);
			if (mul_ctrl.load)
				cnt_q <= '0;
			else if (mul_ctrl.step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// Operand selection for the product in turn.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_TRAP_E: begin
				mul_a = {tilt_err_q[W-1], tilt_err_q} + {e_q[W-1], e_q};
				mul_b = {{(W-DT_W){1'b0}}, dt_q};
			end
			OP_MUL_I: begin
				mul_a = {gain_i_q[W-1], gain_i_q};
				mul_b = tmp_q;
			end
			OP_TRAP_U: begin
				mul_a = {wheel_err_q[W-1], wheel_err_q} + {u_q[W-1], u_q};
				mul_b = {{(W-DT_W){1'b0}}, dt_q};
			end
			OP_MUL_WI: begin
				mul_a = {wheel_gain_i_q[W-1], wheel_gain_i_q};
				mul_b = tmp_q;
			end
			OP_MUL_P: begin
				mul_a = {gain_p_q[W-1], gain_p_q};
				mul_b = e_q;
			end
			OP_MUL_D: begin
				mul_a = {gain_d_q[W-1], gain_d_q};
				mul_b = ed_q;
			end
			OP_MUL_WP: begin
				mul_a = {wheel_gain_p_q[W-1], wheel_gain_p_q};
				mul_b = u_q;
			end
			OP_TRAP_C: begin
				mul_a = {last_eff_q[W-1], last_eff_q} + {eff_q[W-1], eff_q};
				mul_b = {{(W-DT_W){1'b0}}, dt_q};
			end
			default: ;
		endcase
	end

	bpei_mul u_mul (
		.clk     (clk),
		.ctrl    (mul_ctrl),
		.a_in    (mul_a),
		.b_in    (mul_b),
		.product (product)
	);

	// Both readings of the product: trapezoid step and scaled gain term.
	always_comb begin
		trap_sh  = product >>> (DT_FRAC + 1);
		trap_val = trap_sh[W-1:0];
		scaled   = scale_sat(product);
	end

	// Item capture, write-back of each product and the effort sum.
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q  <= neg_sat(tilt_angle);
			ed_q <= neg_sat(tilt_rate);
			u_q  <= neg_sat(wheel_rate);
			dt_q <= sample_period;
		end
		if (post_en) begin
			case (op_q) inside
				OP_TRAP_E, OP_TRAP_U: tmp_q <= trap_val;
				OP_MUL_P:             eff_acc_q <= sx(scaled) + sx(tilt_int_q);
				OP_MUL_D, OP_MUL_WP:  eff_acc_q <= eff_acc_q + sx(scaled);
				default: ;
			endcase
		end
		if (eff_en)
			eff_q <= sat_w(eff_acc_q + sx(wheel_int_q));
	end

	// Controller state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_err_q  <= '0;
			tilt_int_q  <= '0;
			wheel_err_q <= '0;
			wheel_int_q <= '0;
			last_eff_q  <= '0;
			cmd_q       <= '0;
		end else if (post_en) begin
			case (op_q)
				OP_TRAP_E: tilt_err_q  <= e_q;
				OP_MUL_I:  tilt_int_q  <= clamp_lim(sat_w(sx(tilt_int_q) + sx(scaled)),
								    integral_limit_q);
				OP_TRAP_U: wheel_err_q <= u_q;
				OP_MUL_WI: wheel_int_q <= sat_w(sx(wheel_int_q) + sx(scaled));
				OP_TRAP_C: begin
					cmd_q      <= sat_w(sx(cmd_q) + sx(trap_val));
					last_eff_q <= eff_q;
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_en)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_en)
			motor_command_q <= cmd_q;
	end

	assign out_valid     = out_valid_q;
	assign motor_command = motor_command_q;

`ifndef SYNTH
	// An accepted item always starts with the tilt trapezoid.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOAD && op_q == OP_TRAP_E))
		else $error("item did not start with the first product");

	// Write-back happens only after the last digit of a product.
	a_post_after_digits: assert property (@(posedge clk) disable iff (!arst_n)
		post_en |-> ($past(state_q) == ST_MUL && $past(cnt_q) == CNT_W'(DIGITS - 1)))
		else $error("product written back before all digits were taken");

	// The tilt integral stays within the limit after its update.
	a_tilt_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(post_en && op_q == OP_MUL_I) |=>
			(tilt_int_q <= $past(lim_pos) && tilt_int_q >= -$past(lim_pos)))
		else $error("tilt integral outside its limit");

	// A result appears only from the emit step.
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit_en))
		else $error("result item appeared without an emit");
`endif

endmodule

@@ src/bpei_mul.sv @@
// Digit-serial signed multiplier, one radix-16 digit of the serial operand per cycle while step is high.
module bpei_mul import bpei_pkg::*; (
	input  logic                   clk,
	input  mul_ctrl_t              ctrl,
	input  logic signed [A_W-1:0]  a_in,
	input  logic signed [W-1:0]    b_in,
	output logic signed [P_W-1:0]  product
);

	logic signed [A_W-1:0]  a_q;
	logic        [W-1:0]    b_q;
	logic        [HI_W-1:0] hi_q;
	logic        [W-1:0]    lo_q;

	logic [DIGIT_W-1:0]    dig_raw;
	logic [DIGIT_W:0]      dig;
	logic signed [T_W-1:0] a_ext;
	logic signed [T_W-1:0] dig_ext;
	logic signed [T_W-1:0] pp;
	logic        [T_W-1:0] sum_t;

	// Current digit; the top digit of the serial operand carries its sign.
	always_comb begin
		dig_raw = b_q[DIGIT_W-1:0];
		dig     = {ctrl.last & dig_raw[DIGIT_W-1], dig_raw};
		a_ext   = {{(T_W-A_W){a_q[A_W-1]}}, a_q};
		dig_ext = {{(T_W-DIGIT_W-1){dig[DIGIT_W]}}, dig};
		pp      = a_ext * dig_ext;
		sum_t   = {{(T_W-HI_W){hi_q[HI_W-1]}}, hi_q} + pp;
	end

	// Partial product accumulates in the high half; settled digits shift into the low half.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q  <= a_in;
			b_q  <= b_in;
			hi_q <= '0;
		end else if (ctrl.step) begin
			hi_q <= sum_t[T_W-1:DIGIT_W];
			lo_q <= {sum_t[DIGIT_W-1:0], lo_q[W-1:DIGIT_W]};
			b_q  <= {{DIGIT_W{1'b0}}, b_q[W-1:DIGIT_W]};
		end
	end

	assign product = {hi_q, lo_q};

endmodule
